/* design/pfi_pkg.sv */
// Package for the palette fade interpolator: payload words, lane select codes,
// register indexes and the 6-to-8-bit colour widening function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pfi_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;
  // Quotient bits of the per-lane divider; the interpolated step never exceeds 8 bits.
  localparam int DIV_BITS = 8;
  localparam int CFG_IDX_W = 3;

  typedef struct packed {
    logic [7:0] entry_index;
    logic [7:0] step_number;
    logic [7:0] orig_red;
    logic [7:0] orig_green;
    logic [7:0] orig_blue;
    logic [7:0] goal_red;
    logic [7:0] goal_green;
    logic [7:0] goal_blue;
  } pfi_in_word_t;

  typedef struct packed {
    logic [7:0] entry_index_out;
    logic [7:0] new_red;
    logic [7:0] new_green;
    logic [7:0] new_blue;
    logic       is_final;
  } pfi_out_word_t;

  typedef enum logic [1:0] {
    SEL_PASS  = 2'd0,
    SEL_LERP  = 2'd1,
    SEL_FINAL = 2'd2
  } pfi_sel_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FADE_STEPS  = 3'd0,
    CFG_FADE_MODE   = 3'd1,
    CFG_FIRST_ENTRY = 3'd2,
    CFG_LAST_ENTRY  = 3'd3,
    CFG_SOLID_RED   = 3'd4,
    CFG_SOLID_GREEN = 3'd5,
    CFG_SOLID_BLUE  = 3'd6
  } pfi_cfg_idx_t;

  // Side information that travels with each word to the merging stage.
  typedef struct packed {
    logic       vld;
    logic [7:0] index;
    logic       is_final;
  } pfi_side_t;

  // c * 255 / 63 equals 4c plus one for every full 21 in c.
  function automatic logic [7:0] widen6(input logic [5:0] c);
    logic [1:0] extra;
    extra = (c == 6'd63) ? 2'd3 :
            ((c >= 6'd42) ? 2'd2 : ((c >= 6'd21) ? 2'd1 : 2'd0));
    return {c, 2'b00} + {6'd0, extra};
  endfunction

endpackage

`default_nettype wire

/* design/pfi_lane.sv */
// One colour channel lane: signed delta times step, a pipelined restoring
// divider by the step count, then the final add and select.
// Depends on pfi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfi_lane
  import pfi_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       en,
  input  wire logic [7:0] orig,
  input  wire logic [7:0] target,
  input  wire logic [7:0] step,
  input  wire logic [7:0] steps,
  input  wire pfi_sel_t   sel,
  output logic [7:0]      res
);

  localparam int QW = DIV_BITS;
  localparam int PW = 2 * QW;

  logic [PW-1:0] rem_r  [0:QW];
  logic [QW-1:0] quo_r  [0:QW];
  logic          neg_r  [0:QW];
  logic [7:0]    orig_r [0:QW];
  logic [7:0]    tgt_r  [0:QW];
  pfi_sel_t      sel_r  [0:QW];

  logic signed [9:0]  delta;
  logic signed [18:0] prod;
  logic [18:0]        mag;

  always_comb begin
    delta = $signed({2'b00, target}) - $signed({2'b00, orig});
    prod  = delta * $signed({1'b0, step});
    mag   = prod[18] ? 19'(-prod) : 19'(prod);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= mag[PW-1:0];
      quo_r[0]  <= '0;
      neg_r[0]  <= prod[18];
      orig_r[0] <= orig;
      tgt_r[0]  <= target;
      sel_r[0]  <= sel;
    end
  end

  // Stage s decides quotient bit QW-s against the divisor shifted into place.
  for (genvar s = 1; s <= QW; s++) begin : g_div
    logic [PW:0]   trial;
    logic [PW-1:0] rem_nxt;
    logic [QW-1:0] quo_nxt;

    always_comb begin
      trial   = {1'b0, rem_r[s-1]} - ((PW + 1)'(steps) << (QW - s));
      rem_nxt = trial[PW] ? rem_r[s-1] : trial[PW-1:0];
      quo_nxt = quo_r[s-1];
      quo_nxt[QW-s] = ~trial[PW];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        quo_r[s]  <= quo_nxt;
        neg_r[s]  <= neg_r[s-1];
        orig_r[s] <= orig_r[s-1];
        tgt_r[s]  <= tgt_r[s-1];
        sel_r[s]  <= sel_r[s-1];
      end
    end
  end

  always_comb begin
    case (sel_r[QW])
      SEL_FINAL: res = tgt_r[QW];
      SEL_LERP:  res = neg_r[QW] ? orig_r[QW] - quo_r[QW] : orig_r[QW] + quo_r[QW];
      default:   res = orig_r[QW];
    endcase
  end

endmodule

`default_nettype wire

/* design/pfi_merge.sv */
// Merging stage: joins the three lane results with the index and final flag
// into the result word and holds it in the output register.
// Depends on pfi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfi_merge
  import pfi_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       en,
  input  wire pfi_side_t  side,
  input  wire logic [7:0] red,
  input  wire logic [7:0] green,
  input  wire logic [7:0] blue,
  output logic            out_valid,
  output pfi_out_word_t   out_data
);

  logic          out_valid_r;
  pfi_out_word_t out_data_r;
  pfi_out_word_t out_data_nxt;

  always_comb begin
    out_data_nxt.entry_index_out = side.index;
    out_data_nxt.new_red         = red;
    out_data_nxt.new_green       = green;
    out_data_nxt.new_blue        = blue;
    out_data_nxt.is_final        = side.is_final;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= side.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* design/palette_fade_interpolator.sv */
// Palette fade interpolator: one palette entry per word, three channel lanes.
// Throughput one word per cycle while the output is not stalled; a result passes through
// one multiply stage, eight divider stages and the output register.
// The pipeline advances as a whole and holds while a waiting result is stalled.
// Reset loads the register defaults and empties the pipeline; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module palette_fade_interpolator
  import pfi_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire pfi_in_word_t         in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output pfi_out_word_t             out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  localparam int QW = DIV_BITS;

  logic [7:0] fade_steps_r;
  logic       fade_mode_r;
  logic [7:0] first_entry_r;
  logic [7:0] last_entry_r;
  logic [5:0] solid_red_r;
  logic [5:0] solid_green_r;
  logic [5:0] solid_blue_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_steps_r  <= 8'd1;
      fade_mode_r   <= 1'b0;
      first_entry_r <= 8'd0;
      last_entry_r  <= 8'd255;
      solid_red_r   <= 6'd0;
      solid_green_r <= 6'd0;
      solid_blue_r  <= 6'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (pfi_cfg_idx_t'(cfg_index))
        CFG_FADE_STEPS:  fade_steps_r  <= cfg_data;
        CFG_FADE_MODE:   fade_mode_r   <= cfg_data[0];
        CFG_FIRST_ENTRY: first_entry_r <= cfg_data;
        CFG_LAST_ENTRY:  last_entry_r  <= cfg_data;
        CFG_SOLID_RED:   solid_red_r   <= cfg_data[5:0];
        CFG_SOLID_GREEN: solid_green_r <= cfg_data[5:0];
        CFG_SOLID_BLUE:  solid_blue_r  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  logic     adv;
  logic     is_final;
  logic     in_range;
  pfi_sel_t sel;
  logic [7:0] tgt_red, tgt_green, tgt_blue;

  // The whole pipeline moves unless the output register holds a stalled word.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_comb begin
    is_final = in_data.step_number >= fade_steps_r;
    in_range = (in_data.entry_index >= first_entry_r) &&
               (in_data.entry_index <= last_entry_r) &&
               ({1'b0, in_data.entry_index} < 9'(PALETTE_ENTRIES));
    sel = is_final ? SEL_FINAL : (in_range ? SEL_LERP : SEL_PASS);
    if (fade_mode_r) begin
      tgt_red   = in_data.goal_red;
      tgt_green = in_data.goal_green;
      tgt_blue  = in_data.goal_blue;
    end else begin
      tgt_red   = widen6(solid_red_r);
      tgt_green = widen6(solid_green_r);
      tgt_blue  = widen6(solid_blue_r);
    end
  end

  logic [QW:0] vld_r;
  logic [7:0]  idx_r [0:QW];
  logic        fin_r [0:QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[QW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx_r[0] <= in_data.entry_index;
      fin_r[0] <= is_final;
      for (int i = 1; i <= QW; i++) begin
        idx_r[i] <= idx_r[i-1];
        fin_r[i] <= fin_r[i-1];
      end
    end
  end

  logic [7:0] res_red, res_green, res_blue;

  pfi_lane u_lane_red (
    .clk    (clk),
    .en     (adv),
    .orig   (in_data.orig_red),
    .target (tgt_red),
    .step   (in_data.step_number),
    .steps  (fade_steps_r),
    .sel    (sel),
    .res    (res_red)
  );

  pfi_lane u_lane_green (
    .clk    (clk),
    .en     (adv),
    .orig   (in_data.orig_green),
    .target (tgt_green),
    .step   (in_data.step_number),
    .steps  (fade_steps_r),
    .sel    (sel),
    .res    (res_green)
  );

  pfi_lane u_lane_blue (
    .clk    (clk),
    .en     (adv),
    .orig   (in_data.orig_blue),
    .target (tgt_blue),
    .step   (in_data.step_number),
    .steps  (fade_steps_r),
    .sel    (sel),
    .res    (res_blue)
  );

  pfi_side_t side;

  always_comb begin
    side.vld      = vld_r[QW];
    side.index    = idx_r[QW];
    side.is_final = fin_r[QW];
  end

  pfi_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .side      (side),
    .red       (res_red),
    .green     (res_green),
    .blue      (res_blue),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // A word leaving the last divider stage must land in the output register.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && vld_r[QW]) |=> out_valid)
    else $error("word from last stage did not reach output register");

  // While the output is stalled, no word may move inside the pipeline.
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved while output was stalled");

  // An input word is refused only when the output holds a stalled word.
  a_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (out_valid && $stable(vld_r)))
    else $error("input refused without a held result");

endmodule

`default_nettype wire
